// ===== design/rtdd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdd_pkg
// Shared types and constants for the rate-to-display digit formatter.
// ----------------------------------------------------------------------------
package rtdd_pkg;

    localparam int unsigned IN_W    = 36;
    localparam int unsigned SCL_W   = 20;
    localparam int unsigned HALF_W  = 10;
    localparam int unsigned NUM_DIG = 6;

    localparam logic [3:0]       BLANK_DIGIT = 4'd10;
    localparam logic [SCL_W-1:0] MAX_SCALED  = 20'd999999;

    typedef logic [3:0] t_digit;

    // value scaled to fill the field, plus its layout
    typedef struct packed {
        logic [SCL_W-1:0] scaled;
        logic [2:0]       int_dig;
        logic [1:0]       frac;
        logic             wide;
    } t_scaled;

    // six decimal digits, index 0 is the most significant
    typedef struct packed {
        t_digit [0:NUM_DIG-1] bcd;
        logic [2:0]           int_dig;
        logic [1:0]           frac;
        logic                 wide;
    } t_bcd;

    typedef struct packed {
        t_digit [0:NUM_DIG-1] digit;
        logic                 point_shown;
        logic [2:0]           point_slot;
        logic                 wide;
    } t_disp;

endpackage

// ===== design/rtdd_if.sv =====
// ----------------------------------------------------------------------------
// rtdd_if
// Valid/ready channels for the formatter input value and display result.
// ----------------------------------------------------------------------------
interface rtdd_in_if;
    logic        valid;
    logic        ready;
    logic [35:0] rate_value;

    modport source (output valid, output rate_value, input ready);
    modport sink   (input valid, input rate_value, output ready);
endinterface

interface rtdd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit0;
    logic [3:0] digit1;
    logic [3:0] digit2;
    logic [3:0] digit3;
    logic [3:0] digit4;
    logic [3:0] digit5;
    logic       point_shown;
    logic [2:0] point_slot;
    logic       wide_field;

    modport source (output valid, output digit0, output digit1, output digit2,
                    output digit3, output digit4, output digit5,
                    output point_shown, output point_slot, output wide_field,
                    input ready);
    modport sink   (input valid, input digit0, input digit1, input digit2,
                    input digit3, input digit4, input digit5,
                    input point_shown, input point_slot, input wide_field,
                    output ready);
endinterface

// ===== design/rtdd_scale.sv =====
// ----------------------------------------------------------------------------
// rtdd_scale
// Two stages: count integer digits and pick the field, then scale by a
// power of ten and cut off the remaining fraction.
// ----------------------------------------------------------------------------
module rtdd_scale #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rtdd_pkg::IN_W-1:0]     i_raw,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rtdd_pkg::t_scaled             o_data
);

    localparam int unsigned PROD_W = rtdd_pkg::IN_W + rtdd_pkg::HALF_W;

    logic [rtdd_pkg::IN_W-1:0] ipart;
    logic                      sat;
    logic [2:0]                int_dig;
    logic                      wide;
    logic [2:0]                frac_w;

    logic                      r1_v, r2_v;
    logic [rtdd_pkg::IN_W-1:0] r1_raw;
    logic                      r1_sat;
    logic [2:0]                r1_before;
    logic [1:0]                r1_frac;
    logic                      r1_wide;
    rtdd_pkg::t_scaled         r2_data;
    rtdd_pkg::t_scaled         n2_data;

    logic                      en1, en2;
    logic [rtdd_pkg::HALF_W-1:0] p10;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-1:0]         shifted;

    assign en2     = !r2_v || i_ready;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;
    assign o_valid = r2_v;
    assign o_data  = r2_data;

    // stage 1: digit count
    always_comb begin
        ipart   = i_raw >> FRAC_BITS;
        sat     = ipart > 36'd999999;
        int_dig = 3'd1 + {2'b0, ipart >= 36'd10} + {2'b0, ipart >= 36'd100}
                + {2'b0, ipart >= 36'd1000} + {2'b0, ipart >= 36'd10000}
                + {2'b0, ipart >= 36'd100000};
        if (sat) begin
            int_dig = 3'd6;
        end
        wide   = int_dig > 3'd4;
        frac_w = wide ? (3'd6 - int_dig) : (3'd4 - int_dig);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_raw    <= i_raw;
            r1_sat    <= sat;
            r1_before <= int_dig;
            r1_frac   <= frac_w[1:0];
            r1_wide   <= wide;
        end
    end

    // stage 2: scale to fill the field
    always_comb begin
        case (r1_frac)
            2'd0:    p10 = 10'd1;
            2'd1:    p10 = 10'd10;
            2'd2:    p10 = 10'd100;
            2'd3:    p10 = 10'd1000;
            default: p10 = 10'd1;
        endcase
        prod    = PROD_W'(r1_raw) * PROD_W'(p10);
        shifted = prod >> FRAC_BITS;
        n2_data.scaled  = r1_sat ? rtdd_pkg::MAX_SCALED : shifted[rtdd_pkg::SCL_W-1:0];
        n2_data.int_dig = r1_before;
        n2_data.frac    = r1_frac;
        n2_data.wide    = r1_wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_data <= n2_data;
        end
    end

endmodule

// ===== design/rtdd_split.sv =====
// ----------------------------------------------------------------------------
// rtdd_split
// Four stages that split a value below one million into six decimal digits
// by reciprocal multiplication: thousands, then hundreds, then tens.
// ----------------------------------------------------------------------------
module rtdd_split (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rtdd_pkg::t_scaled i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rtdd_pkg::t_bcd    o_data
);

    localparam int unsigned HW = rtdd_pkg::HALF_W;

    logic r3_v, r4_v, r5_v, r6_v;
    logic en3, en4, en5, en6;

    // layout fields ride along each stage
    rtdd_pkg::t_scaled r3_data, r4_data, r5_data;

    logic [HW-1:0]  r3_q0;
    logic [29:0]    q_prod;
    logic [HW-1:0]  n3_q0;

    logic [HW:0]    rem_k;
    logic [HW-1:0]  n4_hi, n4_lo;
    logic [HW-1:0]  r4_hi, r4_lo;

    logic [15:0]    h_prod_hi, h_prod_lo;
    logic [3:0]     n5_hun_hi, n5_hun_lo;
    logic [6:0]     n5_rem_hi, n5_rem_lo;
    logic [3:0]     r5_hun_hi, r5_hun_lo;
    logic [6:0]     r5_rem_hi, r5_rem_lo;

    logic [13:0]    t_prod_hi, t_prod_lo;
    logic [3:0]     ten_hi, ten_lo;
    rtdd_pkg::t_bcd n6_data, r6_data;

    assign en6     = !r6_v || i_ready;
    assign en5     = !r5_v || en6;
    assign en4     = !r4_v || en5;
    assign en3     = !r3_v || en4;
    assign o_ready = en3;
    assign o_valid = r6_v;
    assign o_data  = r6_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (en3) begin
                r3_v <= i_valid;
            end
            if (en4) begin
                r4_v <= r3_v;
            end
            if (en5) begin
                r5_v <= r4_v;
            end
            if (en6) begin
                r6_v <= r5_v;
            end
        end
    end

    // stage 3: estimate value / 1000, low by at most one
    always_comb begin
        q_prod = 30'(i_data.scaled) * 30'd1048;
        n3_q0  = q_prod[29:20];
    end

    // stage 4: correct the estimate, keep quotient and remainder
    always_comb begin
        rem_k = 11'(r3_data.scaled - 20'(r3_q0) * 20'd1000);
        if (rem_k >= 11'd1000) begin
            n4_hi = r3_q0 + 10'd1;
            n4_lo = 10'(rem_k - 11'd1000);
        end else begin
            n4_hi = r3_q0;
            n4_lo = rem_k[HW-1:0];
        end
    end

    // stage 5: hundreds of each half
    always_comb begin
        h_prod_hi = 16'(r4_hi) * 16'd41;
        h_prod_lo = 16'(r4_lo) * 16'd41;
        n5_hun_hi = h_prod_hi[15:12];
        n5_hun_lo = h_prod_lo[15:12];
        n5_rem_hi = 7'(r4_hi - 10'(n5_hun_hi) * 10'd100);
        n5_rem_lo = 7'(r4_lo - 10'(n5_hun_lo) * 10'd100);
    end

    // stage 6: tens and ones
    always_comb begin
        t_prod_hi = 14'(r5_rem_hi) * 14'd103;
        t_prod_lo = 14'(r5_rem_lo) * 14'd103;
        ten_hi    = t_prod_hi[13:10];
        ten_lo    = t_prod_lo[13:10];
        n6_data.bcd[0] = r5_hun_hi;
        n6_data.bcd[1] = ten_hi;
        n6_data.bcd[2] = 4'(r5_rem_hi - 7'(ten_hi) * 7'd10);
        n6_data.bcd[3] = r5_hun_lo;
        n6_data.bcd[4] = ten_lo;
        n6_data.bcd[5] = 4'(r5_rem_lo - 7'(ten_lo) * 7'd10);
        n6_data.int_dig = r5_data.int_dig;
        n6_data.frac    = r5_data.frac;
        n6_data.wide    = r5_data.wide;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_data <= i_data;
            r3_q0   <= n3_q0;
        end
        if (en4) begin
            r4_data <= r3_data;
            r4_hi   <= n4_hi;
            r4_lo   <= n4_lo;
        end
        if (en5) begin
            r5_data   <= r4_data;
            r5_hun_hi <= n5_hun_hi;
            r5_hun_lo <= n5_hun_lo;
            r5_rem_hi <= n5_rem_hi;
            r5_rem_lo <= n5_rem_lo;
        end
        if (en6) begin
            r6_data <= n6_data;
        end
    end

endmodule

// ===== design/rtdd_trim.sv =====
// ----------------------------------------------------------------------------
// rtdd_trim
// Output stage: drop trailing fractional zeros, blank the left side, place
// or drop the decimal point, and hold the result for the consumer.
// ----------------------------------------------------------------------------
module rtdd_trim (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rtdd_pkg::t_bcd   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rtdd_pkg::t_disp  o_data
);

    logic                 r7_v;
    logic                 en7;
    logic [1:0]           k;
    logic [2:0]           idx;
    rtdd_pkg::t_disp      n7_data, r7_data;

    assign en7     = !r7_v || i_ready;
    assign o_ready = en7;
    assign o_valid = r7_v;
    assign o_data  = r7_data;

    always_comb begin
        // trailing zeros, limited to the fractional digits
        k = 2'd0;
        if (i_data.frac >= 2'd1 && i_data.bcd[5] == 4'd0) begin
            k = 2'd1;
            if (i_data.frac >= 2'd2 && i_data.bcd[4] == 4'd0) begin
                k = 2'd2;
                if (i_data.frac >= 2'd3 && i_data.bcd[3] == 4'd0) begin
                    k = 2'd3;
                end
            end
        end
        idx = 3'd0;
        for (int i = 0; i < rtdd_pkg::NUM_DIG; i++) begin
            idx = 3'(i) - {1'b0, k} + (i_data.wide ? 3'd0 : 3'd2);
            if ((!i_data.wide && i >= 4) || (3'(i) < {1'b0, k})) begin
                n7_data.digit[i] = rtdd_pkg::BLANK_DIGIT;
            end else begin
                n7_data.digit[i] = i_data.bcd[idx];
            end
        end
        n7_data.point_shown = i_data.frac > k;
        n7_data.point_slot  = n7_data.point_shown ? (i_data.int_dig + {1'b0, k}) : 3'd0;
        n7_data.wide        = i_data.wide;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en7) begin
            r7_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            r7_data <= n7_data;
        end
    end

endmodule

// ===== design/rate_to_display_digits_unit.sv =====
// ----------------------------------------------------------------------------
// rate_to_display_digits_unit
// Formats an unsigned fixed-point rate as digits for a 4 or 6 digit display.
// ----------------------------------------------------------------------------
// Each request passes through a seven-stage pipeline and is registered at
// every stage; a new request can be taken every cycle while the result side
// keeps up, and a held result drops the input ready once the stages fill.
// The stages are: integer digit count, power-of-ten scaling multiply, two
// stages for the split by one thousand, one each for hundreds and for tens,
// and the output register that trims trailing zeros. Every stage stalls on
// its own, so a held result backs up the pipeline one stage at a time and
// bubbles are squeezed out. An integer part above 999999 shows as 999999.
module rate_to_display_digits_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtdd_in_if.sink    i_rate,
    rtdd_out_if.source o_disp
);

    logic              scl_valid, scl_ready;
    rtdd_pkg::t_scaled scl_data;
    logic              bcd_valid, bcd_ready;
    rtdd_pkg::t_bcd    bcd_data;
    rtdd_pkg::t_disp   disp_data;

    rtdd_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rate.valid),
        .o_ready (i_rate.ready),
        .i_raw   (i_rate.rate_value),
        .o_valid (scl_valid),
        .i_ready (scl_ready),
        .o_data  (scl_data)
    );

    rtdd_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scl_valid),
        .o_ready (scl_ready),
        .i_data  (scl_data),
        .o_valid (bcd_valid),
        .i_ready (bcd_ready),
        .o_data  (bcd_data)
    );

    rtdd_trim u_trim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bcd_valid),
        .o_ready (bcd_ready),
        .i_data  (bcd_data),
        .o_valid (o_disp.valid),
        .i_ready (o_disp.ready),
        .o_data  (disp_data)
    );

    assign o_disp.digit0      = disp_data.digit[0];
    assign o_disp.digit1      = disp_data.digit[1];
    assign o_disp.digit2      = disp_data.digit[2];
    assign o_disp.digit3      = disp_data.digit[3];
    assign o_disp.digit4      = disp_data.digit[4];
    assign o_disp.digit5      = disp_data.digit[5];
    assign o_disp.point_shown = disp_data.point_shown;
    assign o_disp.point_slot  = disp_data.point_slot;
    assign o_disp.wide_field  = disp_data.wide;

endmodule

// ===== tb/sv/tb_rate_to_display_digits_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rate_to_display_digits_unit
// Sends fixed-point rates to the digit formatter over its valid/ready input
// and checks every display result against an in-bench formatter, in order,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_rate_to_display_digits_unit;
    import rtdd_pkg::*;

    localparam int unsigned          FRAC_BITS  = 16;
    localparam logic [IN_W-1:0]      RATE_MAX   = 36'd65535999999;
    localparam longint unsigned      INT_LIMIT  = 999999;
    localparam int unsigned          IDLE_LIMIT = 3000;
    localparam int unsigned          TAIL_WAIT  = 20;
    localparam int unsigned          MAX_REPORT = 60;

    logic i_clk;
    logic i_rst_n;

    rtdd_in_if  rate_if ();
    rtdd_out_if disp_if ();

    rate_to_display_digits_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rate (rate_if),
        .o_disp (disp_if)
    );

    t_disp       pending_disp[$];
    int unsigned err_count;
    int unsigned idle_cycles;
    int unsigned stall_left;
    bit          calm;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- helpers

    // Expected display for one rate value.
    function automatic t_disp format_rate(logic [IN_W-1:0] v);
        longint unsigned raw;
        longint unsigned ipart;
        longint unsigned scaled;
        longint unsigned p;
        int              int_dig;
        int              total;
        int              slot;
        bit              shown;
        t_digit          d[NUM_DIG];
        t_disp           r;

        raw   = longint'(v);
        ipart = raw >> FRAC_BITS;
        if (ipart > INT_LIMIT) begin
            int_dig = 6;
            total   = 6;
            scaled  = INT_LIMIT;
        end else begin
            int_dig = 1;
            p = 10;
            while (int_dig < 6 && ipart >= p) begin
                int_dig++;
                p = p * 10;
            end
            total = (int_dig > 4) ? 6 : 4;
            p = 1;
            repeat (total - int_dig) p = p * 10;
            scaled = (raw * p) >> FRAC_BITS;
        end

        for (int i = 0; i < NUM_DIG; i++) begin
            if (i >= total) begin
                d[i] = BLANK_DIGIT;
            end else begin
                p = 1;
                repeat (total - 1 - i) p = p * 10;
                d[i] = t_digit'((scaled / p) % 10);
            end
        end

        // shift out trailing fractional zeros, blanking from the left
        shown = (int_dig != total);
        slot  = int_dig;
        while (shown && d[total-1] == 4'd0) begin
            for (int i = total - 1; i > 0; i--) begin
                d[i] = d[i-1];
            end
            d[0] = BLANK_DIGIT;
            slot++;
            if (slot >= total) begin
                shown = 1'b0;
            end
        end

        for (int i = 0; i < NUM_DIG; i++) begin
            r.digit[i] = d[i];
        end
        r.point_shown = shown;
        r.point_slot  = shown ? 3'(slot) : 3'd0;
        r.wide        = (total == 6);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report(string what, int got, int want);
        err_count++;
        if (err_count <= MAX_REPORT) begin
            $display("ERROR: %s got %0d expected %0d", what, got, want);
        end
    endtask

    // Send one request; leaves valid high so back-to-back requests never
    // toggle it within one step.
    task automatic push_rate(logic [IN_W-1:0] v);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            rate_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rate_if.valid      <= 1'b1;
        rate_if.rate_value <= v;
        do @(posedge i_clk); while (!rate_if.ready);
        pending_disp.push_back(format_rate(v));
    endtask

    // Hold the sender until every pending result has come back.
    task automatic drain_results();
        rate_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_disp.size() != 0);
    endtask

    function automatic logic [IN_W-1:0] rate_of(longint unsigned ipart,
                                                longint unsigned frac);
        return IN_W'((ipart << FRAC_BITS) | (frac & 64'hFFFF));
    endfunction

    // Integer part with a chosen digit count, fraction either random or coarse
    // so that trailing zeros get trimmed.
    function automatic logic [IN_W-1:0] shaped_rate();
        int unsigned     ndig;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned ipart;
        longint unsigned frac;
        ndig = $urandom_range(1, 6);
        lo = (ndig == 1) ? 0 : 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 1) ? 9 : lo * 10 - 1;
        ipart = lo + ($urandom() % (hi - lo + 1));
        case ($urandom_range(0, 3))
            0: frac = 0;
            1: frac = longint'($urandom_range(0, 15)) << 12;
            default: frac = $urandom_range(0, 65535);
        endcase
        return rate_of(ipart, frac);
    endfunction

    function automatic logic [IN_W-1:0] any_rate();
        logic [IN_W-1:0] v;
        v = {4'($urandom_range(0, 15)), 32'($urandom())};
        if (v > RATE_MAX) begin
            v = v % (RATE_MAX + 1);
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin
        t_disp want;
        if (i_rst_n && disp_if.valid && disp_if.ready) begin
            if (pending_disp.size() == 0) begin
                report("result with no pending request", 1, 0);
            end else begin
                want = pending_disp.pop_front();
                if (disp_if.digit0 !== want.digit[0])
                    report("digit0", disp_if.digit0, want.digit[0]);
                if (disp_if.digit1 !== want.digit[1])
                    report("digit1", disp_if.digit1, want.digit[1]);
                if (disp_if.digit2 !== want.digit[2])
                    report("digit2", disp_if.digit2, want.digit[2]);
                if (disp_if.digit3 !== want.digit[3])
                    report("digit3", disp_if.digit3, want.digit[3]);
                if (disp_if.digit4 !== want.digit[4])
                    report("digit4", disp_if.digit4, want.digit[4]);
                if (disp_if.digit5 !== want.digit[5])
                    report("digit5", disp_if.digit5, want.digit[5]);
                if (disp_if.point_shown !== want.point_shown)
                    report("point_shown", disp_if.point_shown, want.point_shown);
                if (disp_if.point_slot !== want.point_slot)
                    report("point_slot", disp_if.point_slot, want.point_slot);
                if (disp_if.wide_field !== want.wide)
                    report("wide_field", disp_if.wide_field, want.wide);
            end
        end
    end

    // Result-side stalls: mostly short, a few long, none while calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            disp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            disp_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            disp_if.ready <= 1'b0;
            stall_left    <= pick_gap();
        end else begin
            disp_if.ready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither channel moves a request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rate_if.valid && rate_if.ready) || (disp_if.valid && disp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb_rate_to_display_digits_unit NOT OK");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------ tests

    task automatic test_directed();
        push_rate(rate_of(0, 0));
        push_rate(rate_of(0, 1));
        push_rate(rate_of(0, 16'h8000));
        push_rate(rate_of(0, 16'hFFFF));
        push_rate(rate_of(1, 0));
        push_rate(rate_of(1, 16'h8000));
        push_rate(rate_of(2, 16'h4000));
        push_rate(rate_of(9, 16'hFFFF));
        push_rate(rate_of(10, 0));
        push_rate(rate_of(99, 16'h8000));
        push_rate(rate_of(999, 16'h4000));
        push_rate(rate_of(1000, 16'h1000));
        push_rate(rate_of(9999, 0));
        push_rate(rate_of(9999, 16'hFFFF));
        push_rate(rate_of(10000, 0));
        push_rate(rate_of(12345, 16'h8000));
        push_rate(rate_of(99999, 16'hC000));
        push_rate(rate_of(100000, 16'h8000));
        push_rate(rate_of(999999, 0));
        push_rate(RATE_MAX);
        push_rate(36'h7_FFFF_FFFF);
        push_rate(36'h8_0000_0000);
        push_rate(36'h5_5555_5555);
        push_rate(36'h2_AAAA_AAAA);
    endtask

    task automatic test_random_rates(int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                push_rate(any_rate());
            end else begin
                push_rate(shaped_rate());
            end
        end
    endtask

    // Full-rate burst with no gaps on either side.
    task automatic test_back_to_back(int unsigned count);
        calm = 1'b1;
        repeat (count) push_rate(shaped_rate());
        calm = 1'b0;
    endtask

    task automatic test_drain_pauses(int unsigned rounds);
        repeat (rounds) begin
            repeat ($urandom_range(1, 12)) push_rate(shaped_rate());
            drain_results();
        end
    endtask

    initial begin
        err_count          = 0;
        idle_cycles        = 0;
        stall_left         = 0;
        calm               = 1'b0;
        i_rst_n            = 1'b0;
        rate_if.valid      = 1'b0;
        rate_if.rate_value = '0;
        disp_if.ready      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_rates(900);
        test_back_to_back(300);
        test_drain_pauses(30);
        test_random_rates(200);

        rate_if.valid <= 1'b0;
        while (pending_disp.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_rate_to_display_digits_unit OK");
        end else begin
            $display("tb_rate_to_display_digits_unit NOT OK");
        end
        $finish;
    end

endmodule
